// ----- sv/adsr_pkg.sv -----
// adsr_pkg: shared widths, phase codes and register indexes for the linear
// adsr envelope generator and its multiply/divide unit
// depends on: nothing
`default_nettype none

package adsr_pkg;

   localparam int LEN_WIDTH       = 24;
   localparam int SUS_WIDTH       = 16;
   localparam int PHASE_WIDTH     = 3;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 24;

   typedef logic [PHASE_WIDTH-1:0]     phase_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam phase_type PH_IDLE    = 3'd0;
   localparam phase_type PH_ATTACK  = 3'd1;
   localparam phase_type PH_DECAY   = 3'd2;
   localparam phase_type PH_SUSTAIN = 3'd3;
   localparam phase_type PH_RELEASE = 3'd4;

   localparam csr_index_type REG_ATTACK  = 2'd0;
   localparam csr_index_type REG_DECAY   = 2'd1;
   localparam csr_index_type REG_RELEASE = 2'd2;
   localparam csr_index_type REG_SUSTAIN = 2'd3;

   localparam logic [LEN_WIDTH-1:0] ATTACK_RESET  = 24'd480;
   localparam logic [LEN_WIDTH-1:0] DECAY_RESET   = 24'd4800;
   localparam logic [LEN_WIDTH-1:0] RELEASE_RESET = 24'd4800;
   localparam logic [SUS_WIDTH-1:0] SUSTAIN_RESET = 16'd49152;

endpackage

`default_nettype wire

// ----- sv/adsr_muldiv.sv -----
// adsr_muldiv: one multiply then a restoring divide, one quotient bit a cycle
// through a single shared subtractor; quotient must fit QUOT_WIDTH bits
// depends on: adsr_pkg
`default_nettype none

module adsr_muldiv
   import adsr_pkg::*;
#(
   parameter int QUOT_WIDTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [QUOT_WIDTH-1:0] op_a,
   input  wire logic [LEN_WIDTH-1:0]  op_b,
   input  wire logic [LEN_WIDTH-1:0]  den,
   output logic                       done,
   output logic [QUOT_WIDTH-1:0]      quot
);

   localparam int PROD_WIDTH = QUOT_WIDTH + LEN_WIDTH;
   localparam int ITER_WIDTH = $clog2(QUOT_WIDTH);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic                  done_ff, done_in;
   logic [ITER_WIDTH-1:0] iter_ff, iter_in;
   logic [QUOT_WIDTH-1:0] a_ff, a_in;
   logic [LEN_WIDTH-1:0]  b_ff, b_in;
   logic [LEN_WIDTH-1:0]  den_ff, den_in;
   logic [LEN_WIDTH-1:0]  rem_ff, rem_in;
   logic [QUOT_WIDTH-1:0] quot_ff, quot_in;

   logic [PROD_WIDTH-1:0] prod;
   logic [LEN_WIDTH:0]    shifted;
   logic [LEN_WIDTH+1:0]  diff;
   logic                  borrow;

   assign prod    = PROD_WIDTH'(a_ff) * PROD_WIDTH'(b_ff);
   assign shifted = {rem_ff, quot_ff[QUOT_WIDTH-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};
   assign borrow  = diff[LEN_WIDTH+1];

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      iter_in  = iter_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               a_in     = op_a;
               b_in     = op_b;
               den_in   = den;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // high part is below den since the quotient fits
            rem_in   = prod[PROD_WIDTH-1:QUOT_WIDTH];
            quot_in  = prod[QUOT_WIDTH-1:0];
            iter_in  = ITER_WIDTH'(QUOT_WIDTH - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in  = borrow ? shifted[LEN_WIDTH-1:0] : diff[LEN_WIDTH-1:0];
            quot_in = {quot_ff[QUOT_WIDTH-2:0], ~borrow};
            iter_in = iter_ff - 1'b1;
            if (iter_ff == '0) begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      iter_ff <= iter_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

// ----- sv/adsr_linear_envelope.sv -----
// adsr_linear_envelope: linear adsr envelope, one tick per audio sample
// holds the phase sequencer, configuration registers and output register
// depends on: adsr_pkg, adsr_muldiv
//
// channel  dir  handshake              payload
// req      in   req_valid/req_ready    req_gate
// rsp      out  rsp_valid/rsp_ready    rsp_level, rsp_phase
// csr      in   csr_valid/csr_ready    csr_index, csr_wdata
//
// a tick that needs a ramp level passes from transfer through the multiply, the divide
// (one quotient bit a cycle), the done flag and the load of the output register;
// a tick with a fixed level goes from transfer straight to the load
// req_ready is low until the result is loaded
// a stalled rsp holds the next result in the sequencer and the divider output
// reset is synchronous and restores idle phase and register defaults
`default_nettype none

module adsr_linear_envelope
   import adsr_pkg::*;
#(
   parameter int COUNT_WIDTH = 24,
   parameter int LEVEL_WIDTH = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_gate,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [LEVEL_WIDTH-1:0]         rsp_level,
   output logic [PHASE_WIDTH-1:0]         rsp_phase,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   localparam int BIG_WIDTH = (COUNT_WIDTH > LEN_WIDTH) ? COUNT_WIDTH : LEN_WIDTH;
   localparam int SW_WIDTH  = (LEVEL_WIDTH > SUS_WIDTH) ? LEVEL_WIDTH : SUS_WIDTH;
   localparam logic [LEVEL_WIDTH-1:0] FULL      = {LEVEL_WIDTH{1'b1}};
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_WAIT = 2'd1;
   localparam logic [1:0] T_FIN  = 2'd2;

   logic [LEN_WIDTH-1:0]   attack_ff, decay_ff, release_ff;
   logic [SUS_WIDTH-1:0]   sustain_ff;
   logic [1:0]             state_ff, state_in;
   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   prev_gate_ff;
   logic [LEVEL_WIDTH-1:0] hold_ff, hold_in;
   logic                   invert_ff, invert_in;
   logic                   use_div_ff, use_div_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_WIDTH-1:0] rsp_level_ff, rsp_level_in;
   phase_type              rsp_phase_ff, rsp_phase_in;

   logic                   accept;
   logic                   load;
   phase_type              ph0;
   logic [COUNT_WIDTH-1:0] cnt0;
   logic [BIG_WIDTH-1:0]   cx;
   logic [LEN_WIDTH-1:0]   c_len;
   logic [SW_WIDTH-1:0]    sus_x;
   logic [LEVEL_WIDTH-1:0] sus;
   logic                   advance;
   logic [LEVEL_WIDTH-1:0] op_a;
   logic [LEN_WIDTH-1:0]   op_b;
   logic [LEN_WIDTH-1:0]   den;
   logic                   div_done;
   logic [LEVEL_WIDTH-1:0] quot;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == T_IDLE);
   assign csr_ready = 1'b1;
   assign load      = (state_ff == T_FIN) && (!rsp_valid_ff || rsp_ready);

   assign sus_x = SW_WIDTH'(sustain_ff);
   assign sus   = (sus_x > SW_WIDTH'(FULL)) ? FULL : sus_x[LEVEL_WIDTH-1:0];

   // tick evaluation, edges first
   always_comb begin
      ph0  = phase_ff;
      cnt0 = count_ff;
      if (req_gate && !prev_gate_ff) begin
         ph0  = PH_ATTACK;
         cnt0 = '0;
      end
      if (!req_gate && prev_gate_ff) begin
         ph0  = PH_RELEASE;
         cnt0 = '0;
      end
      cx         = BIG_WIDTH'(cnt0);
      c_len      = cx[LEN_WIDTH-1:0];
      phase_in   = ph0;
      count_in   = cnt0;
      advance    = 1'b1;
      hold_in    = '0;
      invert_in  = 1'b0;
      use_div_in = 1'b0;
      op_a       = FULL;
      op_b       = c_len;
      den        = attack_ff;
      unique case (ph0)
         PH_ATTACK: begin
            if (cx >= BIG_WIDTH'(attack_ff)) begin
               phase_in = PH_DECAY;
               count_in = '0;
               hold_in  = FULL;
               advance  = 1'b0;
            end else begin
               use_div_in = 1'b1;
            end
         end
         PH_DECAY: begin
            if (cx >= BIG_WIDTH'(decay_ff)) begin
               phase_in = PH_SUSTAIN;
               count_in = '0;
               hold_in  = sus;
               advance  = 1'b0;
            end else begin
               use_div_in = 1'b1;
               invert_in  = 1'b1;
               op_a       = FULL - sus;
               den        = decay_ff;
            end
         end
         PH_SUSTAIN: begin
            hold_in = sus;
         end
         PH_RELEASE: begin
            if (cx >= BIG_WIDTH'(release_ff)) begin
               phase_in = PH_IDLE;
               advance  = 1'b0;
            end else begin
               use_div_in = 1'b1;
               op_a       = sus;
               op_b       = release_ff - c_len;
               den        = release_ff;
            end
         end
         PH_IDLE: begin
            hold_in = '0;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
      if (advance && (cnt0 != COUNT_MAX)) begin
         count_in = cnt0 + 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (accept) begin
               state_in = use_div_in ? T_WAIT : T_FIN;
            end
         end
         T_WAIT: begin
            if (div_done) begin
               state_in = T_FIN;
            end
         end
         T_FIN: begin
            if (load) begin
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_level_in = rsp_level_ff;
      rsp_phase_in = rsp_phase_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_phase_in = phase_ff;
         if (!use_div_ff) begin
            rsp_level_in = hold_ff;
         end else if (invert_ff) begin
            rsp_level_in = FULL - quot;
         end else begin
            rsp_level_in = quot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff    <= ATTACK_RESET;
         decay_ff     <= DECAY_RESET;
         release_ff   <= RELEASE_RESET;
         sustain_ff   <= SUSTAIN_RESET;
         state_ff     <= T_IDLE;
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         prev_gate_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_ATTACK:  attack_ff  <= csr_wdata[LEN_WIDTH-1:0];
               REG_DECAY:   decay_ff   <= csr_wdata[LEN_WIDTH-1:0];
               REG_RELEASE: release_ff <= csr_wdata[LEN_WIDTH-1:0];
               REG_SUSTAIN: sustain_ff <= csr_wdata[SUS_WIDTH-1:0];
               default: begin
               end
            endcase
         end
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff     <= phase_in;
            count_ff     <= count_in;
            prev_gate_ff <= req_gate;
         end
      end
      if (accept) begin
         hold_ff    <= hold_in;
         invert_ff  <= invert_in;
         use_div_ff <= use_div_in;
      end
      rsp_level_ff <= rsp_level_in;
      rsp_phase_ff <= rsp_phase_in;
   end

   adsr_muldiv #(
      .QUOT_WIDTH (LEVEL_WIDTH)
   ) u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (accept && use_div_in),
      .op_a  (op_a),
      .op_b  (op_b),
      .den   (den),
      .done  (div_done),
      .quot  (quot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = rsp_level_ff;
   assign rsp_phase = rsp_phase_ff;

endmodule

`default_nettype wire

// ----- tb/adsr_linear_envelope_tb.sv -----
// adsr_linear_envelope_tb: self-checking testbench for the linear adsr envelope
// a directed table of ticks and register writes, then random gate patterns under
// changing register settings and backpressure; depends on adsr_pkg, adsr_linear_envelope
`timescale 1ns / 100ps

module adsr_linear_envelope_tb
   import adsr_pkg::*;
();

   localparam int ENV_COUNT_WIDTH = 24;
   localparam int ENV_LEVEL_WIDTH = 16;
   localparam logic [63:0] FULL_SCALE = (64'd1 << ENV_LEVEL_WIDTH) - 1;
   localparam logic [ENV_COUNT_WIDTH-1:0] COUNT_CEILING = '1;
   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 40;
   localparam int CONFIGS_PER_MODE = 3;
   localparam int TICKS_PER_CONFIG = 95;

   typedef struct packed {
      logic [ENV_LEVEL_WIDTH-1:0] level;
      phase_type                  phase;
   } envelope_sample_type;

   typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_type;

   typedef struct packed {
      row_kind_type                kind;
      csr_index_type               index;
      logic [CSR_DATA_WIDTH-1:0]   data;
      logic                        gate;
      logic                        pinned;
      logic [ENV_LEVEL_WIDTH-1:0]  level;
      phase_type                   phase;
   } directed_row_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   wire                         req_ready;
   logic                        req_gate = 1'b0;
   wire                         rsp_valid;
   logic                        rsp_ready = 1'b0;
   wire [ENV_LEVEL_WIDTH-1:0]   rsp_level;
   wire [PHASE_WIDTH-1:0]       rsp_phase;
   logic                        csr_valid = 1'b0;
   wire                         csr_ready;
   csr_index_type               csr_index = REG_ATTACK;
   logic [CSR_DATA_WIDTH-1:0]   csr_wdata = '0;

   // envelope predictor state and its copy of the registers
   logic [LEN_WIDTH-1:0]        len_attack = ATTACK_RESET;
   logic [LEN_WIDTH-1:0]        len_decay = DECAY_RESET;
   logic [LEN_WIDTH-1:0]        len_release = RELEASE_RESET;
   logic [SUS_WIDTH-1:0]        sus_level = SUSTAIN_RESET;
   phase_type                   env_phase = PH_IDLE;
   logic [ENV_COUNT_WIDTH-1:0]  env_count = '0;
   logic                        env_prev_gate = 1'b0;

   envelope_sample_type         expected_samples[$];
   envelope_sample_type         head_sample;
   directed_row_type            directed_rows[$];
   int unsigned                 fail_count = 0;
   int unsigned                 idle_cycles = 0;
   int unsigned                 sender_idle_pct = 24;
   int unsigned                 receiver_idle_pct = 84;
   int unsigned                 hold_seq = 0;
   int unsigned                 hold_seen = 0;
   int unsigned                 hold_left = 0;

   adsr_linear_envelope #(
      .COUNT_WIDTH(ENV_COUNT_WIDTH),
      .LEVEL_WIDTH(ENV_LEVEL_WIDTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_gate(req_gate),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_level(rsp_level),
      .rsp_phase(rsp_phase),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic envelope_sample_type step_envelope(input logic gate);
      logic [63:0]         c;
      logic [63:0]         s;
      logic [63:0]         lvl;
      bit                  advance;
      envelope_sample_type r;
      advance = 1'b1;
      lvl = '0;
      s = 64'(sus_level);
      if (gate && !env_prev_gate) begin
         env_phase = PH_ATTACK;
         env_count = '0;
      end
      if (!gate && env_prev_gate) begin
         env_phase = PH_RELEASE;
         env_count = '0;
      end
      c = 64'(env_count);
      case (env_phase)
         PH_ATTACK: begin
            if (c >= len_attack) begin
               env_phase = PH_DECAY;
               env_count = '0;
               lvl = FULL_SCALE;
               advance = 1'b0;
            end else begin
               lvl = (c * FULL_SCALE) / len_attack;
            end
         end
         PH_DECAY: begin
            if (c >= len_decay) begin
               env_phase = PH_SUSTAIN;
               env_count = '0;
               lvl = s;
               advance = 1'b0;
            end else begin
               lvl = FULL_SCALE - ((FULL_SCALE - s) * c) / len_decay;
            end
         end
         PH_SUSTAIN: lvl = s;
         PH_RELEASE: begin
            if (c >= len_release) begin
               env_phase = PH_IDLE;
               lvl = '0;
               advance = 1'b0;
            end else begin
               lvl = (s * (len_release - c)) / len_release;
            end
         end
         default: begin
            env_phase = PH_IDLE;
            lvl = '0;
         end
      endcase
      if (advance && env_count != COUNT_CEILING)
         env_count = env_count + 1'b1;
      env_prev_gate = gate;
      r.level = lvl[ENV_LEVEL_WIDTH-1:0];
      r.phase = env_phase;
      return r;
   endfunction

   function automatic void store_register(input csr_index_type index,
                                          input logic [CSR_DATA_WIDTH-1:0] data);
      case (index)
         REG_ATTACK:  len_attack = data[LEN_WIDTH-1:0];
         REG_DECAY:   len_decay = data[LEN_WIDTH-1:0];
         REG_RELEASE: len_release = data[LEN_WIDTH-1:0];
         REG_SUSTAIN: sus_level = data[SUS_WIDTH-1:0];
         default: ;
      endcase
   endfunction

   function automatic logic [LEN_WIDTH-1:0] pick_length();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 8)
         return '0;
      if (r < 16)
         return LEN_WIDTH'(1);
      if (r < 24)
         return LEN_WIDTH'($urandom);
      return LEN_WIDTH'($urandom_range(24, 2));
   endfunction

   function automatic void add_row(input row_kind_type kind, input csr_index_type index,
                                   input logic [CSR_DATA_WIDTH-1:0] data, input logic gate,
                                   input logic pinned, input logic [ENV_LEVEL_WIDTH-1:0] level,
                                   input phase_type phase);
      directed_row_type row;
      row.kind = kind;
      row.index = index;
      row.data = data;
      row.gate = gate;
      row.pinned = pinned;
      row.level = level;
      row.phase = phase;
      directed_rows.push_back(row);
   endfunction

   // valid stays high after the transfer; the next call decides whether to drop it
   task automatic send_tick(input logic gate, input logic pinned,
                            input logic [ENV_LEVEL_WIDTH-1:0] level, input phase_type phase);
      envelope_sample_type predicted;
      csr_valid <= 1'b0;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_gate <= gate;
      do @(posedge clock); while (!req_ready);
      predicted = step_envelope(gate);
      if (pinned) begin
         predicted.level = level;
         predicted.phase = phase;
      end
      expected_samples.push_back(predicted);
   endtask

   task automatic write_register(input csr_index_type index,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      store_register(index, data);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_samples.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            $error("unexpected result: level %0d phase %0d", rsp_level, rsp_phase);
            fail_count++;
         end else begin
            head_sample = expected_samples.pop_front();
            if (rsp_level !== head_sample.level) begin
               $error("level: expected %0d, got %0d", head_sample.level, rsp_level);
               fail_count++;
            end
            if (rsp_phase !== head_sample.phase) begin
               $error("phase: expected %0d, got %0d", head_sample.phase, rsp_phase);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL adsr_linear_envelope");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned               high_span;
      int unsigned               low_span;
      int unsigned               ticks;
      logic [CSR_DATA_WIDTH-1:0] sustain_word;
      logic                      wrote_last;

      // after reset, then a short full cycle through every phase
      add_row(ROW_TICK,  REG_ATTACK,  24'd0,       1'b0, 1'b1, 16'd0,     PH_IDLE);
      add_row(ROW_WRITE, REG_ATTACK,  24'd2,       1'b0, 1'b0, 16'd0,     PH_IDLE);
      add_row(ROW_WRITE, REG_DECAY,   24'd2,       1'b0, 1'b0, 16'd0,     PH_IDLE);
      add_row(ROW_WRITE, REG_RELEASE, 24'd2,       1'b0, 1'b0, 16'd0,     PH_IDLE);
      add_row(ROW_WRITE, REG_SUSTAIN, 24'hFF8000,  1'b0, 1'b0, 16'd0,     PH_IDLE);
      add_row(ROW_TICK,  REG_ATTACK,  24'd0,       1'b1, 1'b1, 16'd0,     PH_ATTACK);
      add_row(ROW_TICK,  REG_ATTACK,  24'd0,       1'b1, 1'b0, 16'd0,     PH_IDLE);
      add_row(ROW_TICK,  REG_ATTACK,  24'd0,       1'b1, 1'b1, 16'hFFFF,  PH_DECAY);
      add_row(ROW_TICK,  REG_ATTACK,  24'd0,       1'b1, 1'b1, 16'hFFFF,  PH_DECAY);
      add_row(ROW_TICK,  REG_ATTACK,  24'd0,       1'b1, 1'b0, 16'd0,     PH_IDLE);
      add_row(ROW_TICK,  REG_ATTACK,  24'd0,       1'b1, 1'b1, 16'h8000,  PH_SUSTAIN);
      add_row(ROW_TICK,  REG_ATTACK,  24'd0,       1'b1, 1'b1, 16'h8000,  PH_SUSTAIN);
      add_row(ROW_TICK,  REG_ATTACK,  24'd0,       1'b0, 1'b1, 16'h8000,  PH_RELEASE);
      add_row(ROW_TICK,  REG_ATTACK,  24'd0,       1'b0, 1'b0, 16'd0,     PH_IDLE);
      add_row(ROW_TICK,  REG_ATTACK,  24'd0,       1'b0, 1'b1, 16'd0,     PH_IDLE);
      add_row(ROW_TICK,  REG_ATTACK,  24'd0,       1'b0, 1'b1, 16'd0,     PH_IDLE);
      // zero lengths end each phase on its first sample
      add_row(ROW_WRITE, REG_ATTACK,  24'd0,       1'b0, 1'b0, 16'd0,     PH_IDLE);
      add_row(ROW_WRITE, REG_DECAY,   24'd0,       1'b0, 1'b0, 16'd0,     PH_IDLE);
      add_row(ROW_WRITE, REG_RELEASE, 24'd0,       1'b0, 1'b0, 16'd0,     PH_IDLE);
      add_row(ROW_WRITE, REG_SUSTAIN, 24'h00FFFF,  1'b0, 1'b0, 16'd0,     PH_IDLE);
      add_row(ROW_TICK,  REG_ATTACK,  24'd0,       1'b1, 1'b1, 16'hFFFF,  PH_DECAY);
      add_row(ROW_TICK,  REG_ATTACK,  24'd0,       1'b1, 1'b1, 16'hFFFF,  PH_SUSTAIN);
      add_row(ROW_TICK,  REG_ATTACK,  24'd0,       1'b0, 1'b1, 16'd0,     PH_IDLE);
      add_row(ROW_TICK,  REG_ATTACK,  24'd0,       1'b0, 1'b0, 16'd0,     PH_IDLE);
      // longest attack and release lengths, gate edges in the middle of attack and release
      add_row(ROW_WRITE, REG_ATTACK,  24'hFFFFFF,  1'b0, 1'b0, 16'd0,     PH_IDLE);
      add_row(ROW_WRITE, REG_RELEASE, 24'hFFFFFF,  1'b0, 1'b0, 16'd0,     PH_IDLE);
      add_row(ROW_WRITE, REG_SUSTAIN, 24'h000000,  1'b0, 1'b0, 16'd0,     PH_IDLE);
      add_row(ROW_TICK,  REG_ATTACK,  24'd0,       1'b1, 1'b1, 16'd0,     PH_ATTACK);
      add_row(ROW_TICK,  REG_ATTACK,  24'd0,       1'b1, 1'b0, 16'd0,     PH_IDLE);
      add_row(ROW_TICK,  REG_ATTACK,  24'd0,       1'b0, 1'b1, 16'd0,     PH_RELEASE);
      add_row(ROW_TICK,  REG_ATTACK,  24'd0,       1'b1, 1'b1, 16'd0,     PH_ATTACK);
      add_row(ROW_TICK,  REG_ATTACK,  24'd0,       1'b0, 1'b1, 16'd0,     PH_RELEASE);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      wrote_last = 1'b0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            if (!wrote_last)
               drain_results();
            write_register(directed_rows[i].index, directed_rows[i].data);
            wrote_last = 1'b1;
         end else begin
            send_tick(directed_rows[i].gate, directed_rows[i].pinned,
                      directed_rows[i].level, directed_rows[i].phase);
            wrote_last = 1'b0;
         end
      end

      for (int mode = 0; mode < 3; mode++) begin
         for (int k = 0; k < CONFIGS_PER_MODE; k++) begin
            drain_results();
            case (mode)
               0: begin
                  sender_idle_pct = 24;
                  receiver_idle_pct = 84;
               end
               1: begin
                  sender_idle_pct = 84;
                  receiver_idle_pct = 24;
               end
               default: begin
                  sender_idle_pct = 0;
                  receiver_idle_pct = 0;
               end
            endcase
            write_register(REG_ATTACK, pick_length());
            write_register(REG_DECAY, pick_length());
            write_register(REG_RELEASE, pick_length());
            sustain_word = CSR_DATA_WIDTH'($urandom);
            case ($urandom_range(9))
               0: sustain_word[SUS_WIDTH-1:0] = '0;
               1: sustain_word[SUS_WIDTH-1:0] = '1;
               default: ;
            endcase
            write_register(REG_SUSTAIN, sustain_word);
            // long receiver stall while ticks keep coming
            if (mode == 2 && k == 0)
               hold_seq <= hold_seq + 1;
            ticks = 0;
            while (ticks < TICKS_PER_CONFIG) begin
               if ($urandom_range(99) < 15) begin
                  repeat ($urandom_range(8, 1)) begin
                     send_tick(1'($urandom_range(1)), 1'b0, '0, PH_IDLE);
                     ticks++;
                  end
               end else begin
                  high_span = len_attack + len_decay + 6;
                  if (high_span > 70)
                     high_span = 70;
                  low_span = len_release + 6;
                  if (low_span > 40)
                     low_span = 40;
                  repeat ($urandom_range(high_span, 1)) begin
                     send_tick(1'b1, 1'b0, '0, PH_IDLE);
                     ticks++;
                  end
                  repeat ($urandom_range(low_span, 1)) begin
                     send_tick(1'b0, 1'b0, '0, PH_IDLE);
                     ticks++;
                  end
               end
            end
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_samples.size() == 0)
         $display("PASS adsr_linear_envelope");
      else
         $display("FAIL adsr_linear_envelope");
      $finish;
   end

endmodule
